// ===== design/event_record_deframer_crc32_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Event record deframer assertion macros
// Shared assertion shorthands for the checker of the deframer ports.
// ----------------------------------------------------------------------------
`ifndef EVENT_RECORD_DEFRAMER_CRC32_UNIT_MACROS_SVH
`define EVENT_RECORD_DEFRAMER_CRC32_UNIT_MACROS_SVH

// Checked at every rising edge, switched off while reset is high.
`define ERDC_ASSERT_ON(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define ERDC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/erdc_pkg.sv =====
// ----------------------------------------------------------------------------
// Event record deframer package
// Shared types, constants and the bytewise CRC-32 step.
// ----------------------------------------------------------------------------
package erdc_pkg;

   localparam int unsigned POS_W          = 33;
   localparam int unsigned SEQ_BYTES      = 8;
   localparam int unsigned TYPE_POS       = 16;
   localparam int unsigned LENGTH_POS     = 20;
   localparam int unsigned HEADER_BYTES   = 24;
   localparam int unsigned MIN_BUFFER     = 28;
   localparam int unsigned DEFAULT_QUEUE_DEPTH = 4;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   // Result bus layout, lowest bit first.
   localparam int unsigned RSP_DATA_W       = 248;
   localparam int unsigned RSP_STORED_LSB   = 176;
   localparam int unsigned RSP_COMPUTED_LSB = 208;
   localparam int unsigned RSP_STATUS_LSB   = 240;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_SEQ,
      OP_TS,
      OP_TYPE,
      OP_RSV,
      OP_LEN,
      OP_PAY,
      OP_CRC
   } erdc_op_type;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_STATUS  = 2'd2
   } erdc_kind_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_SHORT    = 2'd1,
      ST_TRUNC    = 2'd2,
      ST_MISMATCH = 2'd3
   } erdc_status_type;

   // One classified input byte, as passed from the front end to the back end.
   typedef struct packed {
      logic [7:0]      byte_val;
      erdc_op_type     op;
      logic            hdr_emit;
      logic            chk_emit;
      logic            end_flag;
      logic            short_emit;
      erdc_status_type short_code;
   } erdc_item_type;

   typedef struct packed {
      erdc_kind_type   kind;
      logic [63:0]     sequence_number;
      logic [63:0]     timestamp_value;
      logic [7:0]      record_type;
      logic [31:0]     payload_size;
      logic [7:0]      payload_value;
      logic [31:0]     stored_check;
      logic [31:0]     computed_check;
      erdc_status_type status_code;
      logic            last_result;
   } erdc_result_type;

   // Reflected CRC-32, one byte per call.
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== design/erdc_front.sv =====
// ----------------------------------------------------------------------------
// Event record deframer front end
// Tracks the byte position and record phase, and classifies each byte.
// ----------------------------------------------------------------------------
module erdc_front
   import erdc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [7:0]    in_byte,
   input  logic          in_end,
   input  logic          q_full,
   output logic          push_valid,
   output erdc_item_type push_item
);

   typedef enum logic [3:0] {
      PH_HEADER  = 4'b0001,
      PH_PAYLOAD = 4'b0010,
      PH_CRC     = 4'b0100,
      PH_DONE    = 4'b1000
   } erdc_phase_type;

   erdc_phase_type     phase_ff, phase_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [31:0]        len_ff, len_in;
   logic [POS_W-1:0]   pos_inc;
   logic               accept;

   assign in_ready   = !q_full;
   assign accept     = in_valid && !q_full;
   assign push_valid = accept;
   assign pos_inc    = pos_ff + POS_W'(1);

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      len_in    = len_ff;
      push_item = '0;
      push_item.byte_val = in_byte;
      push_item.end_flag = in_end;
      push_item.op       = OP_NONE;

      unique case (phase_ff)
         PH_HEADER: begin
            if (pos_ff < POS_W'(SEQ_BYTES)) begin
               push_item.op = OP_SEQ;
            end else if (pos_ff < POS_W'(TYPE_POS)) begin
               push_item.op = OP_TS;
            end else if (pos_ff == POS_W'(TYPE_POS)) begin
               push_item.op = OP_TYPE;
            end else if (pos_ff >= POS_W'(LENGTH_POS)) begin
               push_item.op = OP_LEN;
               len_in = {in_byte, len_ff[31:8]};
            end else begin
               push_item.op = OP_RSV;
            end
            pos_in = pos_inc;
            if (pos_inc == POS_W'(HEADER_BYTES)) begin
               push_item.hdr_emit = 1'b1;
               phase_in = (len_in != 32'd0) ? PH_PAYLOAD : PH_CRC;
            end
         end
         PH_PAYLOAD: begin
            push_item.op = OP_PAY;
            pos_in = pos_inc;
            if (pos_inc == {1'b0, len_ff} + POS_W'(HEADER_BYTES)) begin
               phase_in = PH_CRC;
            end
         end
         PH_CRC: begin
            push_item.op = OP_CRC;
            pos_in = pos_inc;
            if (pos_inc == {1'b0, len_ff} + POS_W'(MIN_BUFFER)) begin
               push_item.chk_emit = 1'b1;
               phase_in = PH_DONE;
            end
         end
         PH_DONE: begin
            push_item.op = OP_NONE;
         end
         default: begin
            push_item.op = OP_NONE;
         end
      endcase

      // The end of the buffer closes any record that is still open.
      if (in_end) begin
         if (phase_in != PH_DONE) begin
            push_item.short_emit = 1'b1;
            push_item.short_code = (pos_in < POS_W'(MIN_BUFFER)) ? ST_SHORT : ST_TRUNC;
         end
         phase_in = PH_HEADER;
         pos_in   = '0;
         len_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         pos_ff   <= '0;
         len_ff   <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
      end
   end

endmodule

// ===== design/erdc_queue.sv =====
// ----------------------------------------------------------------------------
// Event record deframer item queue
// Short first-in first-out buffer of classified bytes between front and back.
// ----------------------------------------------------------------------------
module erdc_queue
   import erdc_pkg::*;
#(
   parameter int unsigned DEPTH = DEFAULT_QUEUE_DEPTH
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  erdc_item_type push_item,
   output logic          full,
   input  logic          pop,
   output logic          head_valid,
   output erdc_item_type head_item
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   erdc_item_type      slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== design/erdc_back.sv =====
// ----------------------------------------------------------------------------
// Event record deframer back end
// Assembles the header fields, runs the CRC-32 and drives the result register.
// ----------------------------------------------------------------------------
module erdc_back
   import erdc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            head_valid,
   input  erdc_item_type   head_item,
   output logic            pop,
   output logic            out_valid,
   input  logic            out_ready,
   output erdc_result_type out_result
);

   logic [63:0]     seq_ff, seq_in;
   logic [63:0]     ts_ff, ts_in;
   logic [7:0]      type_ff, type_in;
   logic [31:0]     len_ff, len_in;
   logic [31:0]     crc_ff, crc_in;
   logic [31:0]     stored_ff, stored_in;
   logic            pend_ff, pend_in;
   erdc_status_type pend_code_ff, pend_code_in;
   logic            rsp_valid_ff, rsp_valid_in;
   erdc_result_type rsp_ff, res_new;
   logic            can_load, load, first;
   logic [31:0]     calc;

   assign can_load   = !rsp_valid_ff || out_ready;
   assign out_valid  = rsp_valid_ff;
   assign out_result = rsp_ff;
   assign calc       = ~crc_ff;

   always_comb begin
      seq_in       = seq_ff;
      ts_in        = ts_ff;
      type_in      = type_ff;
      len_in       = len_ff;
      crc_in       = crc_ff;
      stored_in    = stored_ff;
      pend_in      = pend_ff;
      pend_code_in = pend_code_ff;
      pop          = 1'b0;
      load         = 1'b0;
      first        = 1'b0;
      res_new      = '0;

      if (pend_ff) begin
         // Second result of a byte: the status of a buffer that ended early.
         if (can_load) begin
            load                = 1'b1;
            res_new.kind        = KIND_STATUS;
            res_new.status_code = pend_code_ff;
            res_new.last_result = 1'b1;
            pend_in             = 1'b0;
         end
      end else if (head_valid && can_load) begin
         pop = 1'b1;
         unique case (head_item.op)
            OP_NONE: begin
               crc_in = crc_ff;
            end
            OP_SEQ: begin
               seq_in = {head_item.byte_val, seq_ff[63:8]};
               crc_in = crc32_byte(crc_ff, head_item.byte_val);
            end
            OP_TS: begin
               ts_in  = {head_item.byte_val, ts_ff[63:8]};
               crc_in = crc32_byte(crc_ff, head_item.byte_val);
            end
            OP_TYPE: begin
               type_in = head_item.byte_val;
               crc_in  = crc32_byte(crc_ff, head_item.byte_val);
            end
            OP_RSV: begin
               crc_in = crc32_byte(crc_ff, head_item.byte_val);
            end
            OP_LEN: begin
               len_in = {head_item.byte_val, len_ff[31:8]};
               crc_in = crc32_byte(crc_ff, head_item.byte_val);
            end
            OP_PAY: begin
               crc_in = crc32_byte(crc_ff, head_item.byte_val);
            end
            OP_CRC: begin
               stored_in = {head_item.byte_val, stored_ff[31:8]};
            end
            default: begin
               crc_in = crc_ff;
            end
         endcase

         if (head_item.hdr_emit) begin
            first                   = 1'b1;
            res_new.kind            = KIND_HEADER;
            res_new.sequence_number = seq_in;
            res_new.timestamp_value = ts_in;
            res_new.record_type     = type_in;
            res_new.payload_size    = len_in;
         end else if (head_item.op == OP_PAY) begin
            first                 = 1'b1;
            res_new.kind          = KIND_PAYLOAD;
            res_new.payload_value = head_item.byte_val;
         end else if (head_item.chk_emit) begin
            first                  = 1'b1;
            res_new.kind           = KIND_STATUS;
            res_new.stored_check   = stored_in;
            res_new.computed_check = calc;
            res_new.status_code    = (calc == stored_in) ? ST_OK : ST_MISMATCH;
            res_new.last_result    = 1'b1;
         end

         if (first) begin
            load = 1'b1;
            if (head_item.short_emit) begin
               pend_in      = 1'b1;
               pend_code_in = head_item.short_code;
            end
         end else if (head_item.short_emit) begin
            load                = 1'b1;
            res_new.kind        = KIND_STATUS;
            res_new.status_code = head_item.short_code;
            res_new.last_result = 1'b1;
         end

         // The end of the buffer returns the record state to its start.
         if (head_item.end_flag) begin
            seq_in    = '0;
            ts_in     = '0;
            type_in   = '0;
            len_in    = '0;
            crc_in    = CRC_INIT;
            stored_in = '0;
         end
      end

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (out_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= '0;
         ts_ff        <= '0;
         type_ff      <= '0;
         len_ff       <= '0;
         crc_ff       <= CRC_INIT;
         stored_ff    <= '0;
         pend_ff      <= 1'b0;
         pend_code_ff <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         ts_ff        <= ts_in;
         type_ff      <= type_in;
         len_ff       <= len_in;
         crc_ff       <= crc_in;
         stored_ff    <= stored_in;
         pend_ff      <= pend_in;
         pend_code_ff <= pend_code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= res_new;
      end
   end

endmodule

// ===== design/event_record_deframer_crc32_unit.sv =====
// ----------------------------------------------------------------------------
// Event record deframer with CRC-32 check
// Splits a byte stream of length-prefixed event records into results.
// ----------------------------------------------------------------------------
// The req_ channel carries one buffer byte per transaction in req_tdata, with
// req_tlast on the buffer's last byte. The rsp_ channel returns results:
// rsp_tuser gives the kind (header, payload byte, status), rsp_tlast marks
// the status that closes a buffer, and rsp_tdata carries the fields.
// A header result follows byte 23, each payload byte gives one result, and a
// status follows the last stored CRC byte or an early buffer end. Results
// stream out before the CRC is known, so the consumer drops them on error.
// An accepted byte is registered in the queue, and its result in the back
// end's result register, which drives rsp_. One byte is taken per cycle
// while the queue has room; a byte that yields two results (buffer end on
// the header's last byte or on a payload byte) holds the back end, as
// its single result register issues one result a cycle while rsp_ is taken.
// A four-entry queue between the classifying front end and the back end
// absorbs such holds and stalls of the receiver; req_tready falls only when
// that queue is full. A synchronous reset empties the queue, drops any
// pending result and restarts at the first byte of a new buffer.
// ----------------------------------------------------------------------------
module event_record_deframer_crc32_unit
   import erdc_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // data_byte
   input  logic                  req_tlast,   // buffer_end
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // sequence_number, timestamp_value, record_type, payload_size,
   // payload_value, stored_check, computed_check, status_code, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]            rsp_tuser,   // result_kind
   output logic                  rsp_tlast    // last_result
);

   logic            push_valid;
   erdc_item_type   push_item;
   logic            q_full;
   logic            head_valid;
   erdc_item_type   head_item;
   logic            pop;
   erdc_result_type result;

   erdc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .in_end     (req_tlast),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   erdc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_item  (push_item),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   erdc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tdata = {6'd0,
                       result.status_code,
                       result.computed_check,
                       result.stored_check,
                       result.payload_value,
                       result.payload_size,
                       result.record_type,
                       result.timestamp_value,
                       result.sequence_number};
   assign rsp_tuser = result.kind;
   assign rsp_tlast = result.last_result;

endmodule

// ===== design/erdc_port_checker.sv =====
// ----------------------------------------------------------------------------
// Event record deframer port checker
// Watches the deframer's ports for reset, ordering and result consistency.
// ----------------------------------------------------------------------------
`include "event_record_deframer_crc32_unit_macros.svh"

module erdc_port_checker
   import erdc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]            rsp_tuser,
   input logic                  rsp_tlast
);

   logic        is_status;
   logic        kind_known;
   logic [1:0]  status_bits;
   logic [31:0] stored_bits;
   logic [31:0] computed_bits;

   assign is_status     = (rsp_tuser == KIND_STATUS);
   assign kind_known    = (rsp_tuser == KIND_HEADER) || (rsp_tuser == KIND_PAYLOAD) || is_status;
   assign status_bits   = rsp_tdata[RSP_STATUS_LSB +: 2];
   assign stored_bits   = rsp_tdata[RSP_STORED_LSB +: 32];
   assign computed_bits = rsp_tdata[RSP_COMPUTED_LSB +: 32];

   // After reset the queue is empty and no result is pending.
   `ERDC_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (req_tready && !rsp_tvalid), "reset left a transaction pending")

   `ERDC_ASSERT_ON(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast)), "stalled result changed")

   // Only a status result closes a buffer, and every status does.
   `ERDC_ASSERT_ON(a_last_is_status, clock, reset, rsp_tvalid |-> (rsp_tlast == is_status), "tlast does not match a status result")

   `ERDC_ASSERT_ON(a_kind_defined, clock, reset, rsp_tvalid |-> kind_known, "undefined result kind")

   // A good status means the two checksums agree.
   `ERDC_ASSERT_ON(a_ok_matches, clock, reset, (rsp_tvalid && is_status && (status_bits == ST_OK)) |-> (computed_bits == stored_bits), "ok status with differing CRC values")

endmodule

bind event_record_deframer_crc32_unit erdc_port_checker u_port_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
